// File: design/fdtp_pkg.sv
package fdtp_pkg;

  localparam int unsigned MaxDepth = 15;
  localparam int unsigned DepthW   = $clog2(MaxDepth + 1);
  localparam int unsigned WordW    = 32;
  localparam int unsigned LeftW    = 30;

  localparam logic [WordW-1:0] TokBeginNode = 32'h0000_0001;
  localparam logic [WordW-1:0] TokEndNode   = 32'h0000_0002;
  localparam logic [WordW-1:0] TokProp      = 32'h0000_0003;

  typedef enum logic [2:0] {
    KIND_BEGIN  = 3'd0,
    KIND_NAME   = 3'd1,
    KIND_END    = 3'd2,
    KIND_HEADER = 3'd3,
    KIND_DATA   = 3'd4
  } kind_e;

  typedef struct packed {
    logic [WordW-1:0] word;
    logic             last_word;
  } in_t;

  typedef struct packed {
    kind_e            kind;
    logic [3:0]       depth;
    logic [WordW-1:0] value;
    logic [WordW-1:0] prop_length;
    logic             final_piece;
    logic             depth_error;
  } event_t;

  function automatic logic [WordW-1:0] swap32(input logic [WordW-1:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  function automatic logic has_zero_byte(input logic [WordW-1:0] v);
    return (v[7:0] == 8'h00) || (v[15:8] == 8'h00) ||
           (v[23:16] == 8'h00) || (v[31:24] == 8'h00);
  endfunction

endpackage

// File: design/fdtp_word_if.sv
interface fdtp_word_if;
  logic        valid;
  logic        ready;
  logic [31:0] word;
  logic        last_word;

  modport source (output valid, output word, output last_word, input ready);
  modport sink   (input valid, input word, input last_word, output ready);
endinterface

// File: design/fdtp_event_if.sv
interface fdtp_event_if;
  logic                valid;
  logic                ready;
  fdtp_pkg::kind_e     kind;
  logic [3:0]          depth;
  logic [31:0]         value;
  logic [31:0]         prop_length;
  logic                final_piece;
  logic                depth_error;

  modport source (output valid, output kind, output depth, output value,
                  output prop_length, output final_piece, output depth_error,
                  input ready);
  modport sink   (input valid, input kind, input depth, input value,
                  input prop_length, input final_piece, input depth_error,
                  output ready);
endinterface

// File: design/fdt_struct_token_parser_core.sv
// Device tree structure-block parser: takes one raw big-endian structure word
// per transfer and emits at most one event per word (node begin, name word,
// node end, property header, data word); NOP, END and unknown tokens emit
// nothing. A word can be taken every cycle while the output is not stalled;
// its event reaches the output through the input register, then the result
// register. While an event waits on the output, the input register takes one
// more word and holds it until the result register frees up, unless that word
// emits nothing. Nesting depth saturates at 0 and at the maximum depth with
// depth_error set. No configuration and no startup sequence: the block is
// ready right out of reset.
module fdt_struct_token_parser_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  fdtp_word_if.sink     word_i,
  fdtp_event_if.source  event_o
);

  logic             in_vld;
  fdtp_pkg::in_t    in_item;
  logic             take;
  logic             push;
  logic             room;
  fdtp_pkg::event_t ev;

  fdtp_in_stage u_in_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .word_i (word_i),
    .take_i (take),
    .vld_o  (in_vld),
    .item_o (in_item)
  );

  fdtp_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .vld_i      (in_vld),
    .item_i     (in_item),
    .out_room_i (room),
    .take_o     (take),
    .push_o     (push),
    .ev_o       (ev)
  );

  fdtp_out_stage u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ev_i    (ev),
    .room_o  (room),
    .event_o (event_o)
  );

`ifndef SYNTH
  a_err_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    event_o.valid && event_o.depth_error |->
      (event_o.kind == fdtp_pkg::KIND_BEGIN) || (event_o.kind == fdtp_pkg::KIND_END))
    else $error("depth error on an event that is not a node begin or end");

  a_fin_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    event_o.valid && event_o.final_piece |->
      (event_o.kind == fdtp_pkg::KIND_NAME) || (event_o.kind == fdtp_pkg::KIND_DATA))
    else $error("final piece on an event that is not a name or data word");

  a_len_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    event_o.valid && (event_o.kind != fdtp_pkg::KIND_HEADER) &&
      (event_o.kind != fdtp_pkg::KIND_DATA) |-> (event_o.prop_length == '0))
    else $error("property length on a node event");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> room)
    else $error("event pushed into a full result register");
`endif

endmodule

// File: design/fdtp_in_stage.sv
module fdtp_in_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  fdtp_word_if.sink        word_i,
  input  logic             take_i,
  output logic             vld_o,
  output fdtp_pkg::in_t    item_o
);

  logic          vld_q;
  fdtp_pkg::in_t item_q;
  logic          load;

  assign word_i.ready = !vld_q || take_i;
  assign load         = word_i.valid && word_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (word_i.ready) begin
      vld_q <= word_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.word      <= word_i.word;
      item_q.last_word <= word_i.last_word;
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

// File: design/fdtp_parser.sv
module fdtp_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              vld_i,
  input  fdtp_pkg::in_t     item_i,
  input  logic              out_room_i,
  output logic              take_o,
  output logic              push_o,
  output fdtp_pkg::event_t  ev_o
);

  typedef enum logic [2:0] {
    MODE_TOKEN = 3'd0,
    MODE_NAME  = 3'd1,
    MODE_PLEN  = 3'd2,
    MODE_POFF  = 3'd3,
    MODE_DATA  = 3'd4
  } mode_e;

  mode_e                          mode_q, mode_d;
  logic [fdtp_pkg::DepthW-1:0]    depth_q, depth_d;
  logic [fdtp_pkg::LeftW-1:0]     left_q, left_d;
  logic [fdtp_pkg::WordW-1:0]     held_q, held_d;
  logic [fdtp_pkg::WordW-1:0]     sw;
  logic [fdtp_pkg::WordW-1:0]     held_m1;
  logic                           emit;
  logic                           fin;
  logic                           at_max;
  fdtp_pkg::event_t               ev;

  assign sw      = fdtp_pkg::swap32(item_i.word);
  assign held_m1 = held_q - fdtp_pkg::WordW'(1);
  assign at_max  = depth_q >= fdtp_pkg::DepthW'(fdtp_pkg::MaxDepth);
  assign fin     = fdtp_pkg::has_zero_byte(item_i.word) || item_i.last_word;

  always_comb begin
    mode_d         = mode_q;
    depth_d        = depth_q;
    left_d         = left_q;
    held_d         = held_q;
    emit           = 1'b0;
    ev.kind        = fdtp_pkg::KIND_BEGIN;
    ev.depth       = 4'(depth_q);
    ev.value       = '0;
    ev.prop_length = '0;
    ev.final_piece = 1'b0;
    ev.depth_error = 1'b0;
    case (mode_q)
      MODE_TOKEN: begin
        if (sw == fdtp_pkg::TokBeginNode) begin
          emit           = 1'b1;
          ev.depth_error = at_max;
          mode_d         = MODE_NAME;
        end else if (sw == fdtp_pkg::TokEndNode) begin
          emit    = 1'b1;
          ev.kind = fdtp_pkg::KIND_END;
          if (depth_q == '0) begin
            ev.depth_error = 1'b1;
          end else begin
            depth_d  = depth_q - fdtp_pkg::DepthW'(1);
            ev.depth = 4'(depth_q - fdtp_pkg::DepthW'(1));
          end
        end else if (sw == fdtp_pkg::TokProp) begin
          mode_d = MODE_PLEN;
        end
      end
      MODE_NAME: begin
        emit           = 1'b1;
        ev.kind        = fdtp_pkg::KIND_NAME;
        ev.value       = item_i.word;
        ev.final_piece = fin;
        if (fin) begin
          if (!at_max) begin
            depth_d = depth_q + fdtp_pkg::DepthW'(1);
          end
          mode_d = MODE_TOKEN;
        end
      end
      MODE_PLEN: begin
        held_d = sw;
        mode_d = MODE_POFF;
      end
      MODE_POFF: begin
        emit           = 1'b1;
        ev.kind        = fdtp_pkg::KIND_HEADER;
        ev.value       = sw;
        ev.prop_length = held_q;
        if (held_q == '0) begin
          mode_d = MODE_TOKEN;
        end else begin
          left_d = held_m1[fdtp_pkg::WordW-1:2];
          mode_d = MODE_DATA;
        end
      end
      MODE_DATA: begin
        emit           = 1'b1;
        ev.kind        = fdtp_pkg::KIND_DATA;
        ev.value       = sw;
        ev.prop_length = held_q;
        ev.final_piece = (left_q == '0);
        if (left_q == '0) begin
          mode_d = MODE_TOKEN;
        end else begin
          left_d = left_q - fdtp_pkg::LeftW'(1);
        end
      end
      default: begin
        mode_d = MODE_TOKEN;
      end
    endcase
    if (item_i.last_word) begin
      mode_d = MODE_TOKEN;
      left_d = '0;
    end
  end

  assign take_o = vld_i && (out_room_i || !emit);
  assign push_o = take_o && emit;
  assign ev_o   = ev;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_TOKEN;
      depth_q <= '0;
      left_q  <= '0;
      held_q  <= '0;
    end else if (take_o) begin
      mode_q  <= mode_d;
      depth_q <= depth_d;
      left_q  <= left_d;
      held_q  <= held_d;
    end
  end

endmodule

// File: design/fdtp_out_stage.sv
module fdtp_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  fdtp_pkg::event_t  ev_i,
  output logic              room_o,
  fdtp_event_if.source      event_o
);

  logic             vld_q;
  fdtp_pkg::event_t ev_q;

  assign room_o = !vld_q || event_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (room_o) begin
      vld_q <= push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (room_o && push_i) begin
      ev_q <= ev_i;
    end
  end

  assign event_o.valid       = vld_q;
  assign event_o.kind        = ev_q.kind;
  assign event_o.depth       = ev_q.depth;
  assign event_o.value       = ev_q.value;
  assign event_o.prop_length = ev_q.prop_length;
  assign event_o.final_piece = ev_q.final_piece;
  assign event_o.depth_error = ev_q.depth_error;

endmodule

// File: tb/fdt_struct_token_parser_core_tb.sv
`timescale 1ns / 100ps

module fdt_struct_token_parser_core_tb;

  localparam logic [31:0] TokNop = 32'h0000_0004;
  localparam logic [31:0] TokEnd = 32'h0000_0009;
  localparam int WordTarget = 550;
  localparam int HoldAtWord = 250;
  localparam int HoldCycles = 400;
  localparam int WatchdogLimit = 4000;

  typedef enum logic [2:0] {
    MODE_TOKEN,
    MODE_NAME,
    MODE_PLEN,
    MODE_POFF,
    MODE_DATA
  } parse_mode_e;

  class parse_tracker;
    parse_mode_e mode = MODE_TOKEN;
    int unsigned depth_now = 0;
    logic [29:0] words_left = '0;
    logic [31:0] held_len = '0;
    fdtp_pkg::event_t pending_events[$];
    int fail_count = 0;
    int word_count = 0;
    int event_count = 0;
    int depth_err_count = 0;
    int deepest = 0;

    static function logic [31:0] flip_bytes(logic [31:0] w);
      logic [31:0] r;
      for (int k = 0; k < 4; k++) r[8*k +: 8] = w[8*(3-k) +: 8];
      return r;
    endfunction

    function void take_word(logic [31:0] raw, logic last);
      fdtp_pkg::event_t ev;
      logic [31:0] sw;
      logic [31:0] count;
      bit fires;
      bit zero_byte;
      sw = flip_bytes(raw);
      ev = '0;
      fires = 0;
      word_count++;
      case (mode)
        MODE_TOKEN: begin
          if (sw == fdtp_pkg::TokBeginNode) begin
            ev.kind = fdtp_pkg::KIND_BEGIN;
            ev.depth = depth_now[3:0];
            ev.depth_error = (depth_now >= fdtp_pkg::MaxDepth);
            fires = 1;
            mode = MODE_NAME;
          end else if (sw == fdtp_pkg::TokEndNode) begin
            if (depth_now == 0) ev.depth_error = 1'b1;
            else depth_now--;
            ev.kind = fdtp_pkg::KIND_END;
            ev.depth = depth_now[3:0];
            fires = 1;
          end else if (sw == fdtp_pkg::TokProp) begin
            mode = MODE_PLEN;
          end
        end
        MODE_NAME: begin
          zero_byte = 0;
          for (int k = 0; k < 4; k++) if (raw[8*k +: 8] == 8'h00) zero_byte = 1;
          ev.kind = fdtp_pkg::KIND_NAME;
          ev.depth = depth_now[3:0];
          ev.value = raw;
          ev.final_piece = zero_byte || last;
          fires = 1;
          if (ev.final_piece) begin
            if (depth_now < fdtp_pkg::MaxDepth) depth_now++;
            mode = MODE_TOKEN;
          end
        end
        MODE_PLEN: begin
          held_len = sw;
          mode = MODE_POFF;
        end
        MODE_POFF: begin
          count = (held_len >> 2) + {31'd0, held_len[1:0] != 2'd0};
          ev.kind = fdtp_pkg::KIND_HEADER;
          ev.depth = depth_now[3:0];
          ev.value = sw;
          ev.prop_length = held_len;
          fires = 1;
          if (count == 0) begin
            mode = MODE_TOKEN;
          end else begin
            words_left = 30'(count - 1);
            mode = MODE_DATA;
          end
        end
        MODE_DATA: begin
          ev.kind = fdtp_pkg::KIND_DATA;
          ev.depth = depth_now[3:0];
          ev.value = sw;
          ev.prop_length = held_len;
          ev.final_piece = (words_left == 0);
          fires = 1;
          if (words_left == 0) mode = MODE_TOKEN;
          else words_left--;
        end
        default: mode = MODE_TOKEN;
      endcase
      if (last) begin
        mode = MODE_TOKEN;
        words_left = '0;
      end
      if (depth_now > deepest) deepest = depth_now;
      if (fires) begin
        if (ev.depth_error) depth_err_count++;
        pending_events.push_back(ev);
      end
    endfunction

    function void match_event(fdtp_pkg::event_t got);
      fdtp_pkg::event_t exp;
      event_count++;
      if (pending_events.size() == 0) begin
        $error("unexpected event: kind %0d value %0h", got.kind, got.value);
        fail_count++;
        return;
      end
      exp = pending_events.pop_front();
      if (got.kind !== exp.kind) begin
        $error("kind: expected %0d, got %0d", exp.kind, got.kind);
        fail_count++;
      end
      if (got.depth !== exp.depth) begin
        $error("depth: expected %0d, got %0d", exp.depth, got.depth);
        fail_count++;
      end
      if (got.value !== exp.value) begin
        $error("value: expected %08h, got %08h", exp.value, got.value);
        fail_count++;
      end
      if (got.prop_length !== exp.prop_length) begin
        $error("prop_length: expected %08h, got %08h", exp.prop_length, got.prop_length);
        fail_count++;
      end
      if (got.final_piece !== exp.final_piece) begin
        $error("final_piece: expected %0b, got %0b", exp.final_piece, got.final_piece);
        fail_count++;
      end
      if (got.depth_error !== exp.depth_error) begin
        $error("depth_error: expected %0b, got %0b", exp.depth_error, got.depth_error);
        fail_count++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  bit calm = 0;
  bit hold_req = 0;
  int idle_cycles;
  parse_tracker tracker = new();

  fdtp_word_if word_bus ();
  fdtp_event_if event_bus ();

  fdt_struct_token_parser_core dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .word_i (word_bus),
    .event_o(event_bus)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [31:0] name_word(bit ends);
    logic [31:0] w;
    for (int k = 0; k < 4; k++)
      w[8*k +: 8] = ends ? 8'($urandom_range(0, 255)) : 8'($urandom_range(1, 255));
    if (ends) w[8*$urandom_range(0, 3) +: 8] = 8'h00;
    return w;
  endfunction

  task automatic send_word(logic [31:0] w, logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      word_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    word_bus.valid <= 1'b1;
    word_bus.word <= w;
    word_bus.last_word <= last;
    do @(posedge clk); while (!word_bus.ready);
    tracker.take_word(w, last);
  endtask

  task automatic send_token(logic [31:0] tok, logic last);
    send_word(parse_tracker::flip_bytes(tok), last);
  endtask

  always @(posedge clk) begin
    fdtp_pkg::event_t got;
    if (rst_n && event_bus.valid === 1'b1 && event_bus.ready === 1'b1) begin
      got.kind = event_bus.kind;
      got.depth = event_bus.depth;
      got.value = event_bus.value;
      got.prop_length = event_bus.prop_length;
      got.final_piece = event_bus.final_piece;
      got.depth_error = event_bus.depth_error;
      tracker.match_event(got);
    end
  end

  initial begin
    int stall;
    event_bus.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        event_bus.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 0;
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          event_bus.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      event_bus.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk);
      if ((word_bus.valid === 1'b1 && word_bus.ready === 1'b1) ||
          (event_bus.valid === 1'b1 && event_bus.ready === 1'b1))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin
    logic [31:0] run_words[$];
    logic [31:0] len;
    int items_sent;
    int pick;
    int node_cut;
    int prop_cut;
    int n;
    int cut_at;
    bit diving;
    bit noise;
    bit hold_armed;
    word_bus.valid = 1'b0;
    word_bus.word = '0;
    word_bus.last_word = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_token(TokNop, 1'b0);
    send_token(TokEnd, 1'b0);
    send_token(32'h0000_0007, 1'b0);
    send_word(32'hffff_ffff, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_token(fdtp_pkg::TokEndNode, 1'b0);
    send_token(fdtp_pkg::TokBeginNode, 1'b0);
    send_word(32'h6162_6364, 1'b0);
    send_word(32'h6500_0000, 1'b0);
    send_token(fdtp_pkg::TokProp, 1'b0);
    send_token(32'h0000_0000, 1'b0);
    send_token(32'hffff_ffff, 1'b0);
    send_token(fdtp_pkg::TokProp, 1'b0);
    send_token(32'h0000_0005, 1'b0);
    send_token(32'h0000_0000, 1'b0);
    send_word(32'hffff_ffff, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_token(fdtp_pkg::TokProp, 1'b0);
    send_token(32'h0000_0004, 1'b0);
    send_token(32'h0000_0007, 1'b0);
    send_word(32'h1234_5678, 1'b0);
    send_token(fdtp_pkg::TokEndNode, 1'b0);
    send_token(fdtp_pkg::TokBeginNode, 1'b0);
    send_word(32'h7172_7374, 1'b1);
    send_token(fdtp_pkg::TokEndNode, 1'b1);

    items_sent = 0;
    diving = 1;
    hold_armed = 0;
    while (items_sent < WordTarget) begin
      if ($urandom_range(0, 39) == 0) calm = !calm;
      if ($urandom_range(0, 29) == 0) diving = !diving;
      if (!hold_armed && items_sent >= HoldAtWord) begin
        hold_req = 1;
        hold_armed = 1;
      end
      run_words.delete();
      noise = 0;
      cut_at = -1;
      node_cut = diving ? 50 : 15;
      prop_cut = diving ? 70 : 50;
      pick = $urandom_range(0, 99);
      if (pick < node_cut) begin
        n = $urandom_range(1, 3);
        run_words.push_back(parse_tracker::flip_bytes(fdtp_pkg::TokBeginNode));
        for (int i = 0; i < n; i++) run_words.push_back(name_word(i == n - 1));
      end else if (pick < prop_cut) begin
        pick = $urandom_range(0, 9);
        if (pick < 8) len = $urandom_range(0, 24);
        else if (pick == 8) len = 4 * $urandom_range(1, 6);
        else len = $urandom;
        run_words.push_back(parse_tracker::flip_bytes(fdtp_pkg::TokProp));
        run_words.push_back(parse_tracker::flip_bytes(len));
        run_words.push_back($urandom);
        n = (len >> 2) + (len[1:0] != 2'd0);
        if (n > 6) n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) run_words.push_back($urandom);
        if (n != (len >> 2) + (len[1:0] != 2'd0)) cut_at = run_words.size() - 1;
      end else if (pick < 92) begin
        run_words.push_back(parse_tracker::flip_bytes(fdtp_pkg::TokEndNode));
      end else begin
        noise = 1;
        pick = $urandom_range(0, 2);
        run_words.push_back(pick == 0 ? parse_tracker::flip_bytes(TokNop) :
                            pick == 1 ? parse_tracker::flip_bytes(TokEnd) : $urandom);
      end
      if (cut_at < 0 && $urandom_range(0, 19) == 0)
        cut_at = $urandom_range(0, run_words.size() - 1);
      for (int i = 0; i < run_words.size(); i++) begin
        send_word(run_words[i], i == cut_at);
        if (!noise) items_sent++;
        if (i == cut_at) break;
      end
    end
    word_bus.valid <= 1'b0;

    while (tracker.pending_events.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Sent %0d structure words and checked %0d events.",
             tracker.word_count, tracker.event_count);
    $display("Nesting reached depth %0d; %0d events carried a depth error.",
             tracker.deepest, tracker.depth_err_count);
    if (tracker.fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
